// ===== design/grpc_message_deframer_macros.svh =====
// Assertion macros for the gRPC message deframer.
// Used by grpc_message_deframer.sv; no other dependencies.
`ifndef GRPC_MESSAGE_DEFRAMER_MACROS_SVH
`define GRPC_MESSAGE_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Checked while out of reset.
`define GMD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("gmd assertion failed");

// Checked on every edge, reset included.
`define GMD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gmd assertion failed");

`else

`define GMD_ASSERT(label, clk, rstn, prop)
`define GMD_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== design/gmd_pkg.sv =====
// Shared types and constants for the gRPC message deframer.
// No dependencies.
package gmd_pkg;

    localparam int unsigned LEN_W       = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned CODE_W      = 2;
    localparam int unsigned PCNT_W      = 3;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned OUT_TDATA_W = 16;
    localparam int unsigned OUT_TUSER_W = 3;

    localparam logic [PCNT_W-1:0] PREFIX_LAST = 3'd4;

    localparam logic [LEN_W-1:0] MAX_MSG_RESET = 32'd4194304;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_MSG  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_COMP = 1'd1;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

    localparam logic [CODE_W-1:0] ERR_LENGTH      = 2'd0;
    localparam logic [CODE_W-1:0] ERR_FLAG        = 2'd1;
    localparam logic [CODE_W-1:0] ERR_COMPRESSION = 2'd2;
    localparam logic [CODE_W-1:0] ERR_TRUNCATED   = 2'd3;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              compressed;
        logic              last;
        logic [CODE_W-1:0] error_code;
    } res_t;

endpackage

// ===== design/grpc_message_deframer.sv =====
// gRPC length-prefixed message deframer.
// Usage: byte items enter on s_axis (tuser = cmd: 0 data byte, 1 end of stream,
// tdata = data_byte). Results leave on m_axis: tuser = {compressed, kind},
// tdata = {error_code, payload_byte}, tlast marks the final byte of a message
// or an empty message. Prefix bytes yield no result, but the last may yield an error or empty.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 payload size limit,
// 1 accept_compressed) and cfg_data; cfg_ready is always high. Write only
// while idle.
// Throughput: one item per cycle while the skid register is empty, set by the
// combinational parse of the prefix/payload state and the two-entry output register pair.
// Output: a result is registered into the head (or, if occupied, skid) register.
// Stall: while m_axis_tready is low, one more result is held in a skid
// register; s_axis_tready drops once that register is occupied.
// Reset (rst_n low, asynchronous): parse state and sticky error clear,
// registers return to 4194304 and 0, the output side empties.
// Errors are sticky: every later item returns the held error until reset.
// Depends on gmd_pkg and grpc_message_deframer_macros.svh.
`include "grpc_message_deframer_macros.svh"

module grpc_message_deframer
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [gmd_pkg::BYTE_W-1:0]            s_axis_tdata,  // [7:0] data_byte
    input  logic                                  s_axis_tuser,  // [0] cmd
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [gmd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // [7:0] payload_byte,
                                                                 // [9:8] error_code, rest 0
    output logic [gmd_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,  // [1:0] kind, [2] compressed
    output logic                                  m_axis_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gmd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gmd_pkg::LEN_W-1:0]             cfg_data
);

    logic [gmd_pkg::LEN_W-1:0]  max_msg_reg;
    logic                       acc_comp_reg;

    logic                       in_payload_reg, in_payload_next;
    logic [gmd_pkg::PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic                       flag_reg, flag_next;
    logic                       flag_bad_reg, flag_bad_next;
    logic [gmd_pkg::LEN_W-1:0]  rem_reg, rem_next;
    logic                       err_held_reg, err_held_next;
    logic [gmd_pkg::CODE_W-1:0] err_code_reg, err_code_next;

    gmd_pkg::res_t              res;
    logic                       res_valid;

    gmd_pkg::res_t              head_reg, head_next;
    logic                       head_valid_reg, head_valid_next;
    gmd_pkg::res_t              skid_reg, skid_next;
    logic                       skid_valid_reg, skid_valid_next;

    logic                       in_acc;
    logic                       push;
    logic                       pop;
    logic [gmd_pkg::LEN_W-1:0]  len_full;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign len_full      = {rem_reg[gmd_pkg::LEN_W-gmd_pkg::BYTE_W-1:0], s_axis_tdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_msg_reg  <= gmd_pkg::MAX_MSG_RESET;
            acc_comp_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gmd_pkg::REG_MAX_MSG:  max_msg_reg  <= cfg_data;
                gmd_pkg::REG_ACC_COMP: acc_comp_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        in_payload_next = in_payload_reg;
        pcnt_next       = pcnt_reg;
        flag_next       = flag_reg;
        flag_bad_next   = flag_bad_reg;
        rem_next        = rem_reg;
        err_held_next   = err_held_reg;
        err_code_next   = err_code_reg;
        res             = '0;
        res_valid       = 1'b0;

        if (err_held_reg)
        begin
            res_valid      = 1'b1;
            res.kind       = gmd_pkg::KIND_ERROR;
            res.error_code = err_code_reg;
        end
        else if (s_axis_tuser == gmd_pkg::CMD_END)
        begin
            res_valid = 1'b1;
            if (in_payload_reg || pcnt_reg != '0)
            begin
                err_held_next  = 1'b1;
                err_code_next  = gmd_pkg::ERR_TRUNCATED;
                res.kind       = gmd_pkg::KIND_ERROR;
                res.error_code = gmd_pkg::ERR_TRUNCATED;
            end
            else
            begin
                res.kind = gmd_pkg::KIND_END;
            end
        end
        else if (in_payload_reg)
        begin
            res_valid        = 1'b1;
            res.kind         = gmd_pkg::KIND_PAYLOAD;
            res.payload_byte = s_axis_tdata;
            res.compressed   = flag_reg;
            res.last         = (rem_reg == gmd_pkg::LEN_W'(1));
            rem_next         = rem_reg - gmd_pkg::LEN_W'(1);
            if (rem_reg == gmd_pkg::LEN_W'(1))
            begin
                in_payload_next = 1'b0;
            end
        end
        else if (pcnt_reg == '0)
        begin
            flag_next     = s_axis_tdata[0];
            flag_bad_next = |s_axis_tdata[gmd_pkg::BYTE_W-1:1];
            rem_next      = '0;
            pcnt_next     = gmd_pkg::PCNT_W'(1);
        end
        else
        begin
            rem_next = len_full;
            if (pcnt_reg != gmd_pkg::PREFIX_LAST)
            begin
                pcnt_next = pcnt_reg + gmd_pkg::PCNT_W'(1);
            end
            else
            begin
                pcnt_next = '0;
                if (len_full > max_msg_reg)
                begin
                    res_valid      = 1'b1;
                    err_held_next  = 1'b1;
                    err_code_next  = gmd_pkg::ERR_LENGTH;
                    res.kind       = gmd_pkg::KIND_ERROR;
                    res.error_code = gmd_pkg::ERR_LENGTH;
                end
                else if (flag_bad_reg)
                begin
                    res_valid      = 1'b1;
                    err_held_next  = 1'b1;
                    err_code_next  = gmd_pkg::ERR_FLAG;
                    res.kind       = gmd_pkg::KIND_ERROR;
                    res.error_code = gmd_pkg::ERR_FLAG;
                end
                else if (flag_reg && !acc_comp_reg)
                begin
                    res_valid      = 1'b1;
                    err_held_next  = 1'b1;
                    err_code_next  = gmd_pkg::ERR_COMPRESSION;
                    res.kind       = gmd_pkg::KIND_ERROR;
                    res.error_code = gmd_pkg::ERR_COMPRESSION;
                end
                else if (len_full == '0)
                begin
                    res_valid      = 1'b1;
                    res.kind       = gmd_pkg::KIND_EMPTY;
                    res.compressed = flag_reg;
                    res.last       = 1'b1;
                end
                else
                begin
                    in_payload_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg <= 1'b0;
            pcnt_reg       <= '0;
            flag_reg       <= 1'b0;
            flag_bad_reg   <= 1'b0;
            rem_reg        <= '0;
            err_held_reg   <= 1'b0;
            err_code_reg   <= '0;
        end
        else if (in_acc)
        begin
            in_payload_reg <= in_payload_next;
            pcnt_reg       <= pcnt_next;
            flag_reg       <= flag_next;
            flag_bad_reg   <= flag_bad_next;
            rem_reg        <= rem_next;
            err_held_reg   <= err_held_next;
            err_code_reg   <= err_code_next;
        end
    end

    // output register plus skid entry
    assign push = in_acc && res_valid;
    assign pop  = head_valid_reg && m_axis_tready;

    always_comb
    begin
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            head_next       = skid_reg;
            head_valid_next = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!head_valid_next)
            begin
                head_next       = res;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = head_valid_reg;
    assign m_axis_tdata  = {{(gmd_pkg::OUT_TDATA_W-gmd_pkg::BYTE_W-gmd_pkg::CODE_W){1'b0}},
                            head_reg.error_code, head_reg.payload_byte};
    assign m_axis_tuser  = {head_reg.compressed, head_reg.kind};
    assign m_axis_tlast  = head_reg.last;

    `GMD_ASSERT_ALWAYS(a_skid_behind_head, clk, !rst_n || !skid_valid_reg || head_valid_reg)
    `GMD_ASSERT(a_err_sticky, clk, rst_n, err_held_reg |=> err_held_reg)
    `GMD_ASSERT(a_payload_no_prefix, clk, rst_n,
        in_payload_reg |-> (pcnt_reg == '0 && rem_reg != '0))
    `GMD_ASSERT(a_err_always_reports, clk, rst_n, (in_acc && err_held_reg) |-> push)
    `GMD_ASSERT(a_push_lands, clk, rst_n, push |=> head_valid_reg)

endmodule
